### rtl/core/pitsr_pkg.sv
// pitsr_pkg: shared constants for the packed id table with swap-on-remove.
// Action and status codes, default sizes. No dependencies.
`timescale 1ns / 1ps

package pitsr_pkg;

  // Default table sizes
  localparam int PITSR_MAX_ENTRIES = 64;
  localparam int PITSR_ID_SPACE    = 256;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Action codes (any other code behaves as a lookup)
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

### rtl/core/packed_id_table_swap_remove_unit.sv
// Channel  | Ports                                   | Direction | Handshake
// ---------+-----------------------------------------+-----------+-------------------------
// command  | in_action, in_entity_id                 | in        | start && !busy
// result   | out_status, out_slot, out_moved,        | out       | out_valid, one cycle,
//          | out_moved_id, out_entry_count, out_nonempty          no back-pressure
//
// Each command has an accept step and an execute step: the accept edge issues reads
// of the id-to-slot memory and of the last packed slot; the next edge writes both
// memories back (busy high) and registers the result, shown for one cycle with out_valid.
// A new command can be accepted in the same cycle its predecessor's result shows.
// The single read-modify-write pass over the two memories sets this rate.
// Reset clears the presence bits and the count at once; no clearing pass.
//
// Packed id table with swap-on-remove: top level. Depends on pitsr_pkg.
`timescale 1ns / 1ps

module packed_id_table_swap_remove_unit
  import pitsr_pkg::*;
#(
  parameter int MAX_ENTRIES = PITSR_MAX_ENTRIES,
  parameter int ID_SPACE    = PITSR_ID_SPACE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ACTION_W-1:0]              in_action,
  input  logic [$clog2(ID_SPACE)-1:0]      in_entity_id,
  output logic                             out_valid,
  output logic [STATUS_W-1:0]              out_status,
  output logic [$clog2(MAX_ENTRIES)-1:0]   out_slot,
  output logic                             out_moved,
  output logic [$clog2(ID_SPACE)-1:0]      out_moved_id,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] out_entry_count,
  output logic                             out_nonempty
);

  localparam int ID_W   = $clog2(ID_SPACE);
  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Sequencer and latched command
  logic                state_r, state_nxt;
  logic [ACTION_W-1:0] action_r;
  logic [ID_W-1:0]     id_r;
  logic                known_r;
  logic                accept;

  // Table state
  logic [SLOT_W-1:0]   slot_mem [ID_SPACE];
  logic [ID_W-1:0]     id_mem   [MAX_ENTRIES];
  logic [ID_SPACE-1:0] present_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  // Registered read data
  logic [SLOT_W-1:0]   slot_rd_r;
  logic [ID_W-1:0]     last_id_rd_r;

  // Write-back controls
  logic                slot_we;
  logic [ID_W-1:0]     slot_wa;
  logic [SLOT_W-1:0]   slot_wd;
  logic                id_we;
  logic [SLOT_W-1:0]   id_wa;
  logic [ID_W-1:0]     id_wd;
  logic                pres_set, pres_clr;

  // Result next values
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_nxt, status_r;
  logic [SLOT_W-1:0]   slot_nxt, slot_r;
  logic                moved_nxt, moved_r;
  logic [ID_W-1:0]     moved_id_nxt, moved_id_r;

  logic                id_in_range;
  logic [CNT_W-1:0]    last_cnt;
  logic [SLOT_W-1:0]   last_slot;

  assign busy        = (state_r == S_EXEC);
  assign accept      = start && !busy;
  assign id_in_range = ({1'b0, in_entity_id} < (ID_W + 1)'(ID_SPACE));
  assign last_cnt    = count_r - CNT_W'(1);
  assign last_slot   = last_cnt[SLOT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command latch; presence is sampled from flops at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      id_r     <= in_entity_id;
      known_r  <= id_in_range && present_r[in_entity_id];
    end
  end

  // Id-to-slot memory: one read at accept, one write in the execute cycle
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (accept)  slot_rd_r <= slot_mem[in_entity_id];
  end

  // Packed id memory: read the last occupied slot at accept
  always_ff @(posedge clk) begin
    if (id_we)  id_mem[id_wa] <= id_wd;
    if (accept) last_id_rd_r <= id_mem[last_slot];
  end

  // Execute: decide the result and the write-back
  always_comb begin
    status_nxt   = ST_OK;
    slot_nxt     = '0;
    moved_nxt    = 1'b0;
    moved_id_nxt = '0;
    count_nxt    = count_r;
    slot_we      = 1'b0;
    slot_wa      = id_r;
    slot_wd      = count_r[SLOT_W-1:0];
    id_we        = 1'b0;
    id_wa        = count_r[SLOT_W-1:0];
    id_wd        = id_r;
    pres_set     = 1'b0;
    pres_clr     = 1'b0;
    case (action_r)
      ACT_ADD: begin
        if (known_r) begin
          status_nxt = ST_PRESENT;
          slot_nxt   = slot_rd_r;
        end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
          status_nxt = ST_FULL;
        end else begin
          slot_nxt  = count_r[SLOT_W-1:0];
          slot_we   = 1'b1;
          id_we     = 1'b1;
          pres_set  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!known_r || count_r == '0) begin
          status_nxt = ST_UNKNOWN;
        end else begin
          slot_nxt  = slot_rd_r;
          pres_clr  = 1'b1;
          count_nxt = last_cnt;
          // swap the last entry into the freed slot
          if (slot_rd_r != last_slot) begin
            moved_nxt    = 1'b1;
            moved_id_nxt = last_id_rd_r;
            id_we        = 1'b1;
            id_wa        = slot_rd_r;
            id_wd        = last_id_rd_r;
            slot_we      = 1'b1;
            slot_wa      = last_id_rd_r;
            slot_wd      = slot_rd_r;
          end
        end
      end
      default: begin
        if (!known_r || count_r == '0) begin
          status_nxt = ST_UNKNOWN;
        end else begin
          slot_nxt = slot_rd_r;
        end
      end
    endcase
    if (!busy) begin
      slot_we  = 1'b0;
      id_we    = 1'b0;
      pres_set = 1'b0;
      pres_clr = 1'b0;
      count_nxt = count_r;
    end
  end

  // Presence bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      count_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (pres_set) present_r[id_r] <= 1'b1;
      if (pres_clr) present_r[id_r] <= 1'b0;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      status_r   <= status_nxt;
      slot_r     <= slot_nxt;
      moved_r    <= moved_nxt;
      moved_id_r <= moved_id_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_moved       = moved_r;
  assign out_moved_id    = moved_id_r;
  assign out_entry_count = count_r;
  assign out_nonempty    = (count_r != '0);

endmodule

### rtl/core/pitsr_checker.sv
// pitsr_checker: port-level checks on the packed id table, bound to the top.
// Depends on pitsr_pkg and packed_id_table_swap_remove_unit.
`timescale 1ns / 1ps

module pitsr_checker
  import pitsr_pkg::*;
#(
  parameter int MAX_ENTRIES = PITSR_MAX_ENTRIES,
  parameter int ID_SPACE    = PITSR_ID_SPACE
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [STATUS_W-1:0]              out_status,
  input logic [$clog2(MAX_ENTRIES)-1:0]   out_slot,
  input logic                             out_moved,
  input logic [$clog2(MAX_ENTRIES+1)-1:0] out_entry_count,
  input logic                             out_nonempty
);

  // an accepted command holds busy for exactly one cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_valid) else $error("busy beat not followed by result");

  // every result beat comes from a command
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result beat without command");

  // unknown or full: no slot, no move
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNKNOWN || out_status == ST_FULL)
      |-> out_slot == '0 && !out_moved) else $error("rejected beat carries data");

  // a moved entry lands below the new count
  a_moved_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> out_nonempty &&
      ({1'b0, out_slot} < out_entry_count)) else $error("moved slot out of range");

endmodule

bind packed_id_table_swap_remove_unit pitsr_checker #(
  .MAX_ENTRIES(MAX_ENTRIES),
  .ID_SPACE   (ID_SPACE)
) u_pitsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_slot       (out_slot),
  .out_moved      (out_moved),
  .out_entry_count(out_entry_count),
  .out_nonempty   (out_nonempty)
);

### tb/sv/packed_id_table_swap_remove_unit_tb.sv
// Testbench for packed_id_table_swap_remove_unit: self-checking, with a shadow copy of the
// packed table and id map that predicts each reply. Depends on pitsr_pkg and the unit.
`timescale 1ns / 1ps

module packed_id_table_swap_remove_unit_tb;
  import pitsr_pkg::*;

  localparam int ID_W         = $clog2(PITSR_ID_SPACE);
  localparam int SLOT_W       = $clog2(PITSR_MAX_ENTRIES);
  localparam int CNT_W        = $clog2(PITSR_MAX_ENTRIES + 1);
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 4;

  // Spare action code, decoded by the unit as a lookup
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                moved;
    logic [ID_W-1:0]     moved_id;
    logic [CNT_W-1:0]    entry_count;
    logic                nonempty;
  } table_reply_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic [ACTION_W-1:0] in_action    = '0;
  logic [ID_W-1:0]     in_entity_id = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_moved;
  logic [ID_W-1:0]     out_moved_id;
  logic [CNT_W-1:0]    out_entry_count;
  logic                out_nonempty;

  // Shadow table state
  logic              id_known   [PITSR_ID_SPACE];
  logic [SLOT_W-1:0] slot_map   [PITSR_ID_SPACE];
  logic [ID_W-1:0]   packed_ids [PITSR_MAX_ENTRIES];
  int                live_count;

  table_reply_t owed_replies[$];
  int           mismatch_count  = 0;
  int           cycle_count     = 0;
  int           sender_idle_pct = 0;

  packed_id_table_swap_remove_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_entity_id   (in_entity_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_moved      (out_moved),
    .out_moved_id   (out_moved_id),
    .out_entry_count(out_entry_count),
    .out_nonempty   (out_nonempty)
  );

  always #10 clk = ~clk;

  // Applies one command to the shadow table and returns the reply it should give
  function automatic table_reply_t table_apply(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id);
    table_reply_t    r;
    int              last;
    logic [ID_W-1:0] mid;
    r = '0;
    if (act == ACT_ADD) begin
      if (id_known[id]) begin
        r.status = ST_PRESENT;
        r.slot   = slot_map[id];
      end else if (live_count >= PITSR_MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        r.status                         = ST_OK;
        r.slot                           = SLOT_W'(live_count);
        packed_ids[SLOT_W'(live_count)]  = id;
        slot_map[id]                     = SLOT_W'(live_count);
        id_known[id]                     = 1'b1;
        live_count++;
      end
    end else if (!id_known[id]) begin
      r.status = ST_UNKNOWN;
    end else begin
      r.status = ST_OK;
      r.slot   = slot_map[id];
      if (act == ACT_REMOVE) begin
        // swap the last packed entry into the freed slot unless it is the one removed
        last         = live_count - 1;
        id_known[id] = 1'b0;
        if (int'(r.slot) != last) begin
          mid                = packed_ids[SLOT_W'(last)];
          packed_ids[r.slot] = mid;
          slot_map[mid]      = r.slot;
          r.moved            = 1'b1;
          r.moved_id         = mid;
        end
        live_count = last;
      end
    end
    r.entry_count = CNT_W'(live_count);
    r.nonempty    = (live_count != 0);
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_present_id();
    return packed_ids[SLOT_W'($urandom_range(live_count - 1))];
  endfunction

  function automatic logic [ID_W-1:0] pick_absent_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(PITSR_ID_SPACE - 1)); while (id_known[id]);
    return id;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Sends one command beat, with random idle cycles ahead of it, and predicts its reply
  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_entity_id <= id;
    do @(posedge clk); while (busy);
    owed_replies.push_back(table_apply(act, id));
  endtask

  // Empty-table cases, duplicate add, spare code, swap and last-entry removes
  task automatic test_directed();
    sender_idle_pct = 0;
    send_cmd(ACT_LOOKUP, 8'h00);
    send_cmd(ACT_REMOVE, 8'hFF);
    send_cmd(ACT_ADD,    8'h00);
    send_cmd(ACT_ADD,    8'hFF);
    send_cmd(ACT_ADD,    8'h55);
    send_cmd(ACT_ADD,    8'hAA);
    send_cmd(ACT_ADD,    8'hFF);
    send_cmd(ACT_LOOKUP, 8'hAA);
    send_cmd(ACT_SPARE,  8'h55);
    send_cmd(ACT_SPARE,  8'h01);
    send_cmd(ACT_REMOVE, 8'h00);
    send_cmd(ACT_REMOVE, 8'hAA);
    send_cmd(ACT_REMOVE, 8'hFF);
    send_cmd(ACT_REMOVE, 8'hFF);
    send_cmd(ACT_LOOKUP, 8'h55);
    send_cmd(ACT_REMOVE, 8'h55);
    send_cmd(ACT_LOOKUP, 8'h55);
  endtask

  // Fill to capacity, poke the full table, then drain it in random order
  task automatic test_full_table();
    sender_idle_pct = 20;
    while (live_count < PITSR_MAX_ENTRIES) send_cmd(ACT_ADD, pick_absent_id());
    send_cmd(ACT_ADD, pick_absent_id());
    send_cmd(ACT_ADD, pick_present_id());
    send_cmd(ACT_LOOKUP, packed_ids[SLOT_W'(PITSR_MAX_ENTRIES - 1)]);
    send_cmd(ACT_REMOVE, pick_present_id());
    send_cmd(ACT_ADD, pick_absent_id());
    send_cmd(ACT_ADD, pick_absent_id());
    while (live_count > 0) send_cmd(ACT_REMOVE, pick_present_id());
  endtask

  // Random traffic that swings the table between empty and full, with some noise
  task automatic test_random(input int n_cmds, input int idle_pct);
    bit growing;
    int roll;
    growing         = 1'b1;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_cmds; i++) begin
      if (live_count == PITSR_MAX_ENTRIES) growing = 1'b0;
      else if (live_count == 0) growing = 1'b1;
      else if ($urandom_range(99) < 3) growing = !growing;
      roll = $urandom_range(99);
      if (roll < 10)
        send_cmd(ACTION_W'($urandom_range(3)), ID_W'($urandom_range(PITSR_ID_SPACE - 1)));
      else if (roll < 75) begin
        // mostly move toward the current goal, sometimes against it
        if (growing == (roll < 60) || live_count == 0)
          send_cmd(ACT_ADD, live_count == PITSR_MAX_ENTRIES ? pick_present_id()
                                                            : pick_absent_id());
        else
          send_cmd(ACT_REMOVE, pick_present_id());
      end else if (roll < 88)
        send_cmd(ACT_LOOKUP, live_count > 0 ? pick_present_id()
                                            : ID_W'($urandom_range(PITSR_ID_SPACE - 1)));
      else if (roll < 94)
        send_cmd(ACT_ADD, live_count > 0 ? pick_present_id()
                                         : ID_W'($urandom_range(PITSR_ID_SPACE - 1)));
      else if (live_count < PITSR_MAX_ENTRIES)
        send_cmd($urandom_range(1) ? ACT_REMOVE : ACT_LOOKUP, pick_absent_id());
      else
        send_cmd(ACT_REMOVE, pick_present_id());
    end
  endtask

  // Result checker: every strobed beat is matched against the oldest prediction
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst_n && out_valid) begin
      if (owed_replies.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = owed_replies.pop_front();
        check_field("status",      32'(out_status),      32'(want.status));
        check_field("slot",        32'(out_slot),        32'(want.slot));
        check_field("moved",       32'(out_moved),       32'(want.moved));
        check_field("moved_id",    32'(out_moved_id),    32'(want.moved_id));
        check_field("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        check_field("nonempty",    32'(out_nonempty),    32'(want.nonempty));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (id_known[i]) id_known[i] = 1'b0;
    live_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_random(600, 0);
    test_random(600, 57);
    test_random(600, 30);

    start <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### packed_id_table_swap_remove_unit.f
rtl/core/pitsr_pkg.sv
rtl/core/packed_id_table_swap_remove_unit.sv
rtl/core/pitsr_checker.sv
tb/sv/packed_id_table_swap_remove_unit_tb.sv
